FILE: hdl/pirc_pkg.sv
package pirc_pkg;

    localparam int INDEX_BITS_DEF      = 8;
    localparam int RANGES_PER_SLOT_DEF = 8;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef enum logic [2:0] {
        OUT_CONTAINED  = 3'd0,
        OUT_EXTENDED   = 3'd1,
        OUT_APPENDED   = 3'd2,
        OUT_DROPPED    = 3'd3,
        OUT_READ_VALID = 3'd4,
        OUT_READ_EMPTY = 3'd5
    } outcome_t;

    // one stored range, exclusive end
    typedef struct packed {
        logic [31:0] r_end;
        logic [31:0] r_start;
    } range_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic commit;
        logic ready;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } sts_t;

endpackage

FILE: hdl/pirc_ctrl.sv
module pirc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  pirc_pkg::sts_t sts,
    output pirc_pkg::cmd_t cmd
);
    import pirc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!sts.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.ready   = 1'b1;
                cmd.capture = in_valid;
            end
            ST_EXEC:
            begin
                cmd.commit = !sts.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: hdl/pirc_datapath.sv
module pirc_datapath #(
    parameter int INDEX_BITS      = pirc_pkg::INDEX_BITS_DEF,
    parameter int RANGES_PER_SLOT = pirc_pkg::RANGES_PER_SLOT_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  pirc_pkg::cmd_t cmd,
    output pirc_pkg::sts_t sts,
    input  logic           req_type,
    input  logic [31:0]    instr_address,
    input  logic [31:0]    mem_address,
    input  logic [7:0]     access_bytes,
    input  logic [2:0]     entry_select,
    input  logic           out_stall,
    output logic           out_valid,
    output logic [2:0]     outcome,
    output logic [2:0]     entry_index,
    output logic [31:0]    range_start,
    output logic [31:0]    range_end,
    output logic [3:0]     entry_count
);
    import pirc_pkg::*;

    localparam int SLOTS = 1 << INDEX_BITS;
    localparam int EW    = (RANGES_PER_SLOT > 1) ? $clog2(RANGES_PER_SLOT) : 1;
    localparam int CW    = $clog2(RANGES_PER_SLOT + 1);

    // slot rows and fill counts
    range_t [RANGES_PER_SLOT-1:0] row_mem [SLOTS];
    logic   [CW-1:0]              cnt_mem [SLOTS];

    range_t [RANGES_PER_SLOT-1:0] row_rd_reg;
    logic   [CW-1:0]              cnt_rd_reg;

    logic                  req_type_reg;
    logic [INDEX_BITS-1:0] slot_reg;
    logic [31:0]           addr_reg;
    logic [31:0]           end_reg;
    logic [2:0]            sel_reg;
    logic [INDEX_BITS-1:0] clr_cnt_reg;

    logic                  out_valid_reg;
    outcome_t              outcome_reg;
    logic [2:0]            entry_index_reg;
    logic [31:0]           range_start_reg;
    logic [31:0]           range_end_reg;
    logic [3:0]            entry_count_reg;

    outcome_t              res_outcome;
    logic [2:0]            res_index;
    logic [31:0]           res_start;
    logic [31:0]           res_end;
    logic [3:0]            res_count;

    logic                  found;
    logic [EW-1:0]         hit_idx;
    range_t                hit;
    logic                  contained;
    logic                  full;
    logic                  sel_ok;
    range_t                sel_entry;
    range_t [RANGES_PER_SLOT-1:0] row_wr;
    logic                  row_we;
    logic                  cnt_we;
    logic [INDEX_BITS-1:0] cnt_waddr;
    logic [CW-1:0]         cnt_wdata;
    logic [CW-1:0]         cnt_inc;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            row_rd_reg   <= row_mem[instr_address[INDEX_BITS-1:0]];
            cnt_rd_reg   <= cnt_mem[instr_address[INDEX_BITS-1:0]];
            req_type_reg <= req_type;
            slot_reg     <= instr_address[INDEX_BITS-1:0];
            addr_reg     <= mem_address;
            end_reg      <= mem_address + {24'd0, access_bytes};
            sel_reg      <= entry_select;
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[slot_reg] <= row_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // first entry below the count that contains, overlaps or touches the access
    always_comb
    begin
        found   = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < RANGES_PER_SLOT; i++)
        begin
            if (!found && (CW'(i) < cnt_rd_reg) &&
                ((end_reg <= row_rd_reg[i].r_end && addr_reg >= row_rd_reg[i].r_start) ||
                 (end_reg > row_rd_reg[i].r_end && addr_reg <= row_rd_reg[i].r_end) ||
                 (end_reg >= row_rd_reg[i].r_start && addr_reg < row_rd_reg[i].r_start)))
            begin
                found   = 1'b1;
                hit_idx = EW'(i);
            end
        end
    end

    assign hit       = row_rd_reg[hit_idx];
    assign contained = (end_reg <= hit.r_end) && (addr_reg >= hit.r_start);
    assign full      = (cnt_rd_reg == CW'(RANGES_PER_SLOT));
    assign sel_ok    = ({{CW{1'b0}}, sel_reg} < {3'd0, cnt_rd_reg});
    assign sel_entry = row_rd_reg[EW'(sel_reg)];
    assign cnt_inc   = cnt_rd_reg + 1'b1;

    always_comb
    begin
        res_outcome = OUT_DROPPED;
        res_index   = '0;
        res_start   = addr_reg;
        res_end     = end_reg;
        res_count   = 4'(cnt_rd_reg);
        row_wr      = row_rd_reg;
        row_we      = 1'b0;
        cnt_we      = cmd.clear;
        cnt_waddr   = clr_cnt_reg;
        cnt_wdata   = '0;
        if (req_type_reg)
        begin
            res_index = sel_reg;
            if (sel_ok)
            begin
                res_outcome = OUT_READ_VALID;
                res_start   = sel_entry.r_start;
                res_end     = sel_entry.r_end;
            end
            else
            begin
                res_outcome = OUT_READ_EMPTY;
                res_start   = '0;
                res_end     = '0;
            end
        end
        else if (found)
        begin
            res_index = 3'(hit_idx);
            if (contained)
            begin
                res_outcome = OUT_CONTAINED;
                res_start   = hit.r_start;
                res_end     = hit.r_end;
            end
            else
            begin
                // widen to the union of both spans
                res_outcome = OUT_EXTENDED;
                res_start   = (addr_reg < hit.r_start) ? addr_reg : hit.r_start;
                res_end     = (end_reg > hit.r_end) ? end_reg : hit.r_end;
                row_wr[hit_idx].r_start = res_start;
                row_wr[hit_idx].r_end   = res_end;
                row_we      = cmd.commit;
            end
        end
        else if (!full)
        begin
            res_outcome = OUT_APPENDED;
            res_index   = 3'(cnt_rd_reg);
            res_count   = 4'(cnt_inc);
            row_wr[cnt_rd_reg[EW-1:0]].r_start = addr_reg;
            row_wr[cnt_rd_reg[EW-1:0]].r_end   = end_reg;
            row_we      = cmd.commit;
            if (cmd.commit)
            begin
                cnt_we    = 1'b1;
                cnt_waddr = slot_reg;
                cnt_wdata = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            outcome_reg     <= res_outcome;
            entry_index_reg <= res_index;
            range_start_reg <= res_start;
            range_end_reg   <= res_end;
            entry_count_reg <= res_count;
        end
    end

    assign sts = '{clear_last: (clr_cnt_reg == {INDEX_BITS{1'b1}}),
                   out_busy:   (out_valid_reg && out_stall)};

    assign out_valid   = out_valid_reg;
    assign outcome     = outcome_reg;
    assign entry_index = entry_index_reg;
    assign range_start = range_start_reg;
    assign range_end   = range_end_reg;
    assign entry_count = entry_count_reg;

endmodule

FILE: hdl/per_instruction_range_coalescer_top.sv
// per-instruction memory range coalescer
// request channel: in_valid / in_stall with req_type, instr_address, mem_address,
//   access_bytes and entry_select. req_type 0 records an access into the slot picked
//   by the low INDEX_BITS of instr_address, req_type 1 reads back one stored range
// result channel: out_valid / out_stall with outcome, entry_index, range_start,
//   range_end and entry_count, one result per request, in request order
// a request is taken at an edge with valid high and stall low
// a request is registered with its slot row read at acceptance; the result is
//   then registered into the output register; no new request is taken until the
//   read-modify-write of the slot row memory (compare and write-back) is done
// reset: a clearing pass walks every entry of the slot count memory, with
//   in_stall high for its whole length
// a stalled result holds in the output register; one more request is taken
//   meanwhile and its write-back waits until the held result is taken
module per_instruction_range_coalescer_top #(
    parameter int INDEX_BITS      = pirc_pkg::INDEX_BITS_DEF,
    parameter int RANGES_PER_SLOT = pirc_pkg::RANGES_PER_SLOT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [31:0] instr_address,
    input  logic [31:0] mem_address,
    input  logic [7:0]  access_bytes,
    input  logic [2:0]  entry_select,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  outcome,
    output logic [2:0]  entry_index,
    output logic [31:0] range_start,
    output logic [31:0] range_end,
    output logic [3:0]  entry_count
);
    import pirc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    pirc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd)
    );

    pirc_datapath #(
        .INDEX_BITS      (INDEX_BITS),
        .RANGES_PER_SLOT (RANGES_PER_SLOT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .req_type      (req_type),
        .instr_address (instr_address),
        .mem_address   (mem_address),
        .access_bytes  (access_bytes),
        .entry_select  (entry_select),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .outcome       (outcome),
        .entry_index   (entry_index),
        .range_start   (range_start),
        .range_end     (range_end),
        .entry_count   (entry_count)
    );

    assign in_stall = !cmd.ready;

    // a taken request always occupies the next cycle
    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request taken on consecutive cycles");

    // a new result only appears out of a busy cycle
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a request in progress");

    a_empty_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && outcome == OUT_READ_EMPTY) |-> (range_start == 32'd0 &&
        range_end == 32'd0))
        else $error("empty read returned a range");

    a_drop_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && outcome == OUT_DROPPED) |-> (entry_index == 3'd0))
        else $error("dropped access with nonzero entry index");

endmodule

FILE: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pirc_pkg::*;

    localparam int SLOT_BITS  = INDEX_BITS_DEF;
    localparam int SLOTS      = 1 << SLOT_BITS;
    localparam int WAYS       = RANGES_PER_SLOT_DEF;
    localparam int RAND_ITEMS = 1225;
    localparam int HOLD_LEN   = 300;
    localparam int LIMIT      = 200000;
    localparam bit REQ_RECORD = 1'b0;
    localparam bit REQ_READ   = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] instr;
        logic [31:0] mem;
        logic [7:0]  nbytes;
        logic [2:0]  sel;
    } request_t;

    typedef struct packed {
        outcome_t    oc;
        logic [2:0]  idx;
        logic [31:0] rs;
        logic [31:0] re;
        logic [3:0]  cnt;
    } range_result_t;

    typedef struct packed {
        request_t      rq;
        logic          typed;
        range_result_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [31:0] instr_address;
    logic [31:0] mem_address;
    logic [7:0]  access_bytes;
    logic [2:0]  entry_select;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  outcome;
    logic [2:0]  entry_index;
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic [3:0]  entry_count;

    // shadow of the profiler table
    logic [3:0]  slot_fill [SLOTS];
    logic [31:0] span_lo [SLOTS*WAYS];
    logic [31:0] span_hi [SLOTS*WAYS];

    range_result_t pending_ranges[$];
    stim_row_t     stim_rows[$];
    int            errors;
    int            cycles;
    int            gap_max;
    int            stall_max;
    bit            hold_req;

    per_instruction_range_coalescer_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .instr_address (instr_address),
        .mem_address   (mem_address),
        .access_bytes  (access_bytes),
        .entry_select  (entry_select),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .outcome       (outcome),
        .entry_index   (entry_index),
        .range_start   (range_start),
        .range_end     (range_end),
        .entry_count   (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic range_result_t coalesce_access(request_t r);
        logic [SLOT_BITS-1:0] slot;
        logic [3:0]           cnt;
        logic [31:0]          fin;
        logic [31:0]          lo;
        logic [31:0]          hi;
        int                   base;
        int                   i;
        bit                   done;
        range_result_t        o;
        slot = r.instr[SLOT_BITS-1:0];
        cnt  = slot_fill[slot];
        base = int'(slot) * WAYS;
        fin  = r.mem + {24'd0, r.nbytes};
        done = 1'b0;
        o    = '0;
        if (r.kind == REQ_READ)
        begin
            if ({1'b0, r.sel} < cnt)
                o = '{OUT_READ_VALID, r.sel, span_lo[base + r.sel], span_hi[base + r.sel], cnt};
            else
                o = '{OUT_READ_EMPTY, r.sel, 32'd0, 32'd0, cnt};
            return o;
        end
        // first matching range wins
        for (i = 0; i < int'(cnt) && !done; i++)
        begin
            lo = span_lo[base + i];
            hi = span_hi[base + i];
            if (fin <= hi && r.mem >= lo)
            begin
                o = '{OUT_CONTAINED, i[2:0], lo, hi, cnt};
                done = 1'b1;
            end
            else if ((fin > hi && r.mem <= hi) || (fin >= lo && r.mem < lo))
            begin
                if (r.mem < lo)
                    lo = r.mem;
                if (fin > hi)
                    hi = fin;
                span_lo[base + i] = lo;
                span_hi[base + i] = hi;
                o = '{OUT_EXTENDED, i[2:0], lo, hi, cnt};
                done = 1'b1;
            end
        end
        if (!done)
        begin
            if (cnt < WAYS)
            begin
                span_lo[base + cnt] = r.mem;
                span_hi[base + cnt] = fin;
                slot_fill[slot] = cnt + 4'd1;
                o = '{OUT_APPENDED, cnt[2:0], r.mem, fin, cnt + 4'd1};
            end
            else
                o = '{OUT_DROPPED, 3'd0, r.mem, fin, 4'(WAYS)};
        end
        return o;
    endfunction

    function automatic request_t rec_req(logic [31:0] instr, logic [31:0] mem,
                                         logic [7:0] nbytes);
        request_t r;
        r = '{REQ_RECORD, instr, mem, nbytes, 3'($urandom_range(0, 7))};
        return r;
    endfunction

    function automatic request_t read_req(logic [31:0] instr, logic [2:0] sel);
        request_t r;
        r = '{REQ_READ, instr, $urandom, 8'($urandom_range(0, 255)), sel};
        return r;
    endfunction

    function automatic range_result_t typed_res(outcome_t oc, logic [2:0] idx,
                                                logic [31:0] rs, logic [31:0] re,
                                                logic [3:0] cnt);
        range_result_t o;
        o = '{oc, idx, rs, re, cnt};
        return o;
    endfunction

    task automatic add_row(request_t rq, logic typed, range_result_t want);
        stim_row_t row;
        row = '{rq, typed, want};
        stim_rows = {stim_rows, row};
    endtask

    // mostly clustered accesses on a few hot slots so ranges merge and fill up
    function automatic request_t random_request();
        logic [7:0]  hot [8];
        logic [7:0]  slot;
        logic [31:0] instr;
        logic [31:0] mem;
        hot = '{8'h00, 8'h01, 8'h02, 8'h55, 8'haa, 8'h7f, 8'h80, 8'hff};
        if ($urandom_range(0, 3) == 0)
            slot = 8'($urandom_range(0, 255));
        else
            slot = hot[$urandom_range(0, 7)];
        instr = {24'($urandom), slot};
        if ($urandom_range(0, 3) == 0)
            return read_req(instr, 3'($urandom_range(0, 7)));
        case ($urandom_range(0, 9)) inside
            0:       mem = $urandom;
            1:       mem = 32'hffff_ff00 + $urandom_range(0, 255);
            [2:5]:   mem = {slot, 24'd0} + $urandom_range(0, 1023);
            default: mem = {slot, 24'd0} + ($urandom_range(0, 15) << 12)
                           + $urandom_range(0, 63);
        endcase
        return rec_req(instr, mem, 8'($urandom_range(0, 255)));
    endfunction

    task automatic push_request(request_t r, logic typed, range_result_t want);
        int            gap;
        range_result_t pred;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= r.kind;
        instr_address <= r.instr;
        mem_address   <= r.mem;
        access_bytes  <= r.nbytes;
        entry_select  <= r.sel;
        do
            @(posedge clk);
        while (in_stall);
        pred = coalesce_access(r);
        pending_ranges = {pending_ranges, (typed ? want : pred)};
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("per_instruction_range_coalescer_top test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        range_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_ranges.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none actual outcome %0d",
                         $realtime, outcome);
            end
            else
            begin
                exp_r = pending_ranges.pop_front();
                check_field("outcome", 32'(exp_r.oc), 32'(outcome));
                check_field("entry_index", 32'(exp_r.idx), 32'(entry_index));
                check_field("range_start", exp_r.rs, range_start);
                check_field("range_end", exp_r.re, range_end);
                check_field("entry_count", 32'(exp_r.cnt), 32'(entry_count));
            end
        end
    end

    // result side back-pressure
    initial
    begin
        int n;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                n = HOLD_LEN;
            end
            else
                n = $urandom_range(0, stall_max);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    initial
    begin
        int k;
        errors        = 0;
        cycles        = 0;
        gap_max       = 8;
        stall_max     = 8;
        hold_req      = 1'b0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        req_type      <= REQ_RECORD;
        instr_address <= '0;
        mem_address   <= '0;
        access_bytes  <= '0;
        entry_select  <= '0;
        for (k = 0; k < SLOTS; k++)
            slot_fill[k] = '0;

        // empty table after reset
        add_row(read_req(32'h0000_0000, 3'd0), 1'b1,
                typed_res(OUT_READ_EMPTY, 3'd0, 32'd0, 32'd0, 4'd0));
        add_row(read_req(32'hffff_ffff, 3'd7), 1'b1,
                typed_res(OUT_READ_EMPTY, 3'd7, 32'd0, 32'd0, 4'd0));
        add_row(rec_req(32'h0000_0001, 32'h0000_1000, 8'd16), 1'b1,
                typed_res(OUT_APPENDED, 3'd0, 32'h0000_1000, 32'h0000_1010, 4'd1));
        // contained, overlap at the end, touching end, touching start, overlap start
        add_row(rec_req(32'h1234_5601, 32'h0000_1004, 8'd4), 1'b0, '0);
        add_row(rec_req(32'h0000_0001, 32'h0000_1008, 8'd16), 1'b0, '0);
        add_row(rec_req(32'h0000_0001, 32'h0000_1018, 8'd8), 1'b0, '0);
        add_row(rec_req(32'h0000_0001, 32'h0000_0ff0, 8'd16), 1'b0, '0);
        add_row(rec_req(32'h0000_0001, 32'h0000_0f00, 8'd255), 1'b0, '0);
        add_row(read_req(32'h0000_0001, 3'd0), 1'b0, '0);
        // zero width access, twice
        add_row(rec_req(32'h0000_0002, 32'h0000_2000, 8'd0), 1'b0, '0);
        add_row(rec_req(32'h0000_0002, 32'h0000_2000, 8'd0), 1'b0, '0);
        // end wraps past the top of the address space
        add_row(rec_req(32'h0000_0003, 32'hffff_fff0, 8'h20), 1'b0, '0);
        add_row(rec_req(32'hffff_ffff, 32'hffff_ffff, 8'hff), 1'b0, '0);
        add_row(rec_req(32'hffff_ffff, 32'h0000_0000, 8'h00), 1'b0, '0);
        // fill one slot with disjoint ranges, then overflow it
        for (k = 0; k < WAYS; k++)
            add_row(rec_req(32'h0000_0004, 32'(k) << 16, 8'd1), 1'b0, '0);
        add_row(rec_req(32'h0000_0004, 32'h0009_0000, 8'd1), 1'b1,
                typed_res(OUT_DROPPED, 3'd0, 32'h0009_0000, 32'h0009_0001, 4'(WAYS)));
        add_row(read_req(32'h0000_0004, 3'd7), 1'b0, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < stim_rows.size(); k++)
            push_request(stim_rows[k].rq, stim_rows[k].typed, stim_rows[k].want);

        for (k = 0; k < RAND_ITEMS; k++)
        begin
            if (k % 100 == 0)
            begin
                gap_max   = $urandom_range(0, 1) * 8;
                stall_max = $urandom_range(0, 1) * 8;
            end
            // long result hold while requests keep coming back to back
            if (k == 500)
            begin
                gap_max  = 0;
                hold_req = 1'b1;
            end
            push_request(random_request(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pending_ranges.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("per_instruction_range_coalescer_top test passed");
        else
            $display("per_instruction_range_coalescer_top test failed");
        $finish;
    end

endmodule

FILE: per_instruction_range_coalescer_top.f
hdl/pirc_pkg.sv
hdl/pirc_ctrl.sv
hdl/pirc_datapath.sv
hdl/per_instruction_range_coalescer_top.sv
tb/tb.sv
